/* hw/rtl/tcc_pkg.sv */
// Shared types and constants for the tilt-compensated compass.
// Depends on nothing; every other RTL file refers to it by scoped names.
package tcc_pkg;

	// Item modes
	localparam logic [1:0] MODE_START   = 2'd0;
	localparam logic [1:0] MODE_CAL     = 2'd1;
	localparam logic [1:0] MODE_FINISH  = 2'd2;
	localparam logic [1:0] MODE_HEADING = 2'd3;

	// CORDIC datapath widths: vector lanes and Q3.28 angle
	localparam int DW = 42;
	localparam int AW = 32;

	localparam logic signed [AW-1:0] ANG_PI      = 32'sd843314857;
	localparam logic signed [AW-1:0] ANG_HALF_PI = 32'sd421657428;
	localparam logic signed [DW-1:0] INV_GAIN    = 42'sd652032874;

	localparam int ATAN_DEPTH = 24;
	localparam logic signed [AW-1:0] ATAN_TAB [ATAN_DEPTH] = '{
		32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
		32'sd16755422, 32'sd8385879, 32'sd4193963, 32'sd2097109,
		32'sd1048571, 32'sd524287, 32'sd262144, 32'sd131072,
		32'sd65536, 32'sd32768, 32'sd16384, 32'sd8192,
		32'sd4096, 32'sd2048, 32'sd1024, 32'sd512,
		32'sd256, 32'sd128, 32'sd64, 32'sd32
	};

	// Register map
	localparam logic REG_DECLINATION = 1'b0;
	localparam logic signed [15:0] DECL_RESET = -16'sd45;

	// One classified item as it travels from front to back
	typedef struct packed {
		logic               heading;
		logic signed [16:0] mx;
		logic signed [16:0] my;
		logic signed [16:0] mz;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic signed [15:0] off_x;
		logic signed [15:0] off_y;
		logic signed [15:0] off_z;
	} item_t;

	typedef struct packed {
		logic                 start;
		logic                 vec;
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [AW-1:0] z;
	} cordic_req_t;

	typedef struct packed {
		logic                 done;
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [AW-1:0] z;
	} cordic_rsp_t;

endpackage

/* hw/rtl/tcc_front.sv */
// Front end: accepts items, runs min/max hard-iron calibration and removes offsets.
// Depends on tcc_pkg.
module tcc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [1:0]          mode,
	input  logic signed [15:0]  mag_x,
	input  logic signed [15:0]  mag_y,
	input  logic signed [15:0]  mag_z,
	input  logic signed [15:0]  accel_x,
	input  logic signed [15:0]  accel_y,
	input  logic signed [15:0]  accel_z,
	input  logic                q_full,
	output logic                q_wr,
	output tcc_pkg::item_t      q_data
);

	logic signed [15:0] min_x_q, max_x_q, min_y_q, max_y_q, min_z_q, max_z_q;
	logic signed [15:0] hi_x_q, hi_y_q, hi_z_q;
	logic signed [15:0] min_x_n, max_x_n, min_y_n, max_y_n, min_z_n, max_z_n;
	logic signed [15:0] hi_x_n, hi_y_n, hi_z_n;
	logic               accept;

	function automatic logic signed [15:0] mid(input logic signed [15:0] mn,
			input logic signed [15:0] mx);
		logic signed [16:0] d;
		logic signed [16:0] h;
		d = 17'(mx) - 17'(mn);
		h = (d + 17'(d[16])) >>> 1;
		return 16'(17'(mn) + h);
	endfunction

	assign accept = push && !q_full;
	assign q_wr   = accept;

	// Next calibration state for this item
	always_comb begin
		min_x_n = min_x_q; max_x_n = max_x_q;
		min_y_n = min_y_q; max_y_n = max_y_q;
		min_z_n = min_z_q; max_z_n = max_z_q;
		hi_x_n  = hi_x_q;  hi_y_n  = hi_y_q;  hi_z_n = hi_z_q;
		unique case (mode)
			tcc_pkg::MODE_START: begin
				min_x_n = mag_x; max_x_n = mag_x;
				min_y_n = mag_y; max_y_n = mag_y;
				min_z_n = mag_z; max_z_n = mag_z;
			end
			tcc_pkg::MODE_CAL: begin
				if (min_x_q > mag_x) min_x_n = mag_x;
				else if (max_x_q < mag_x) max_x_n = mag_x;
				if (min_y_q > mag_y) min_y_n = mag_y;
				else if (max_y_q < mag_y) max_y_n = mag_y;
				if (min_z_q > mag_z) min_z_n = mag_z;
				else if (max_z_q < mag_z) max_z_n = mag_z;
			end
			tcc_pkg::MODE_FINISH: begin
				hi_x_n = mid(min_x_q, max_x_q);
				hi_y_n = mid(min_y_q, max_y_q);
				hi_z_n = mid(min_z_q, max_z_q);
			end
			default: begin
			end
		endcase
	end

	// Build the queue entry
	always_comb begin
		q_data.heading = (mode == tcc_pkg::MODE_HEADING);
		q_data.mx      = 17'(mag_x) - 17'(hi_x_q);
		q_data.my      = 17'(mag_y) - 17'(hi_y_q);
		q_data.mz      = 17'(mag_z) - 17'(hi_z_q);
		q_data.ax      = accel_x;
		q_data.ay      = accel_y;
		q_data.az      = accel_z;
		q_data.off_x   = hi_x_n;
		q_data.off_y   = hi_y_n;
		q_data.off_z   = hi_z_n;
	end

	// Update calibration state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q <= '0; max_x_q <= '0;
			min_y_q <= '0; max_y_q <= '0;
			min_z_q <= '0; max_z_q <= '0;
			hi_x_q  <= '0; hi_y_q  <= '0; hi_z_q <= '0;
		end else if (accept) begin
			min_x_q <= min_x_n; max_x_q <= max_x_n;
			min_y_q <= min_y_n; max_y_q <= max_y_n;
			min_z_q <= min_z_n; max_z_q <= max_z_n;
			hi_x_q  <= hi_x_n;  hi_y_q  <= hi_y_n;  hi_z_q <= hi_z_n;
		end
	end

endmodule

/* hw/rtl/tcc_queue.sv */
// Two-entry queue of classified items between front and back.
// Depends on tcc_pkg.
module tcc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  tcc_pkg::item_t wr_data,
	input  logic           rd,
	output tcc_pkg::item_t rd_data,
	output logic           full,
	output logic           empty
);

	tcc_pkg::item_t mem_q [2];
	logic           wr_ptr_q, rd_ptr_q;
	logic [1:0]     cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rd_data = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr) wr_ptr_q <= !wr_ptr_q;
			if (rd) rd_ptr_q <= !rd_ptr_q;
			if (wr && !rd) cnt_q <= cnt_q + 2'd1;
			else if (rd && !wr) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

/* hw/rtl/tcc_cordic.sv */
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
// Depends on tcc_pkg for widths, angle constants and the arctangent table.
module tcc_cordic #(
	parameter int STAGES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tcc_pkg::cordic_req_t req,
	output tcc_pkg::cordic_rsp_t rsp
);

	localparam int CW = $clog2(STAGES);

	logic signed [tcc_pkg::DW-1:0] x_q, y_q, x_n, y_n, xs, ys;
	logic signed [tcc_pkg::AW-1:0] z_q, z_n, at;
	logic [CW-1:0]                 cnt_q;
	logic                          busy_q, vec_q, neg_q, done_q, last;

	assign xs   = x_q >>> cnt_q;
	assign ys   = y_q >>> cnt_q;
	assign at   = tcc_pkg::ATAN_TAB[5'(cnt_q)];
	assign last = (cnt_q == CW'(STAGES - 1));

	// One micro-rotation
	always_comb begin
		if (vec_q) begin
			if (!y_q[tcc_pkg::DW-1]) begin
				x_n = x_q + ys; y_n = y_q - xs; z_n = z_q + at;
			end else begin
				x_n = x_q - ys; y_n = y_q + xs; z_n = z_q - at;
			end
		end else begin
			if (!z_q[tcc_pkg::AW-1]) begin
				x_n = x_q - ys; y_n = y_q + xs; z_n = z_q - at;
			end else begin
				x_n = x_q + ys; y_n = y_q - xs; z_n = z_q + at;
			end
		end
	end

	// Load with quadrant fold, iterate, unfold rotation-mode results at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			vec_q  <= 1'b0;
			neg_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				vec_q  <= req.vec;
				neg_q  <= !req.vec && ((req.z > tcc_pkg::ANG_HALF_PI) ||
					(req.z < -tcc_pkg::ANG_HALF_PI));
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			if (req.vec) begin
				if (req.x[tcc_pkg::DW-1]) begin
					x_q <= -req.x;
					y_q <= -req.y;
					z_q <= req.y[tcc_pkg::DW-1] ? -tcc_pkg::ANG_PI : tcc_pkg::ANG_PI;
				end else begin
					x_q <= req.x;
					y_q <= req.y;
					z_q <= '0;
				end
			end else begin
				x_q <= tcc_pkg::INV_GAIN;
				y_q <= '0;
				if (req.z > tcc_pkg::ANG_HALF_PI) z_q <= req.z - tcc_pkg::ANG_PI;
				else if (req.z < -tcc_pkg::ANG_HALF_PI) z_q <= req.z + tcc_pkg::ANG_PI;
				else z_q <= req.z;
			end
		end else if (busy_q) begin
			x_q <= (last && neg_q) ? -x_n : x_n;
			y_q <= (last && neg_q) ? -y_n : y_n;
			z_q <= z_n;
		end
	end

	assign rsp.done = done_q;
	assign rsp.x    = x_q;
	assign rsp.y    = y_q;
	assign rsp.z    = z_q;

endmodule

/* hw/rtl/tcc_back.sv */
// Back end: sequencer with one shared multiplier, square root and CORDIC;
// holds the result slot. Depends on tcc_pkg and tcc_cordic.
module tcc_back #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  tcc_pkg::item_t      q_data,
	output logic                q_rd,
	input  logic signed [15:0]  declination,
	input  logic                pop,
	output logic                empty,
	output logic signed [16:0]  heading_centideg,
	output logic                heading_valid,
	output logic signed [15:0]  offset_report_x,
	output logic signed [15:0]  offset_report_y,
	output logic signed [15:0]  offset_report_z
);

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_SQA     = 5'd1;
	localparam logic [4:0] S_SQB     = 5'd2;
	localparam logic [4:0] S_SQRT    = 5'd3;
	localparam logic [4:0] S_ROLL_I  = 5'd4;
	localparam logic [4:0] S_ROLL_W  = 5'd5;
	localparam logic [4:0] S_PITCH_I = 5'd6;
	localparam logic [4:0] S_PITCH_W = 5'd7;
	localparam logic [4:0] S_SCR_I   = 5'd8;
	localparam logic [4:0] S_SCR_W   = 5'd9;
	localparam logic [4:0] S_SCP_I   = 5'd10;
	localparam logic [4:0] S_SCP_W   = 5'd11;
	localparam logic [4:0] S_M1      = 5'd12;
	localparam logic [4:0] S_M2      = 5'd13;
	localparam logic [4:0] S_M3      = 5'd14;
	localparam logic [4:0] S_M4      = 5'd15;
	localparam logic [4:0] S_M5      = 5'd16;
	localparam logic [4:0] S_M6      = 5'd17;
	localparam logic [4:0] S_M7      = 5'd18;
	localparam logic [4:0] S_HEAD_I  = 5'd19;
	localparam logic [4:0] S_HEAD_W  = 5'd20;
	localparam logic [4:0] S_SCALE   = 5'd21;
	localparam logic [4:0] S_FIN     = 5'd22;
	localparam logic [4:0] S_DONE    = 5'd23;

	localparam logic signed [16:0] HDG_SCALE = 17'sd5730;

	logic [4:0]                    state_q;
	tcc_pkg::item_t                item_q;
	logic [31:0]                   sq_q, rem_q, res_q, bitv, trial, res_n;
	logic [3:0]                    k_q;
	logic [15:0]                   r_q;
	logic signed [31:0]            roll_q, pitch_q, ang_q;
	logic signed [15:0]            cr_q, sr_q, cp_q, sp_q;
	logic signed [31:0]            t1_q, t2_q;
	logic signed [49:0]            acc_q;
	logic signed [35:0]            xh_q, yh_q;
	logic signed [45:0]            prod_q;
	logic signed [16:0]            hdg_q;
	logic signed [31:0]            mul_a;
	logic signed [16:0]            mul_b;
	logic signed [48:0]            mul_p;
	logic signed [46:0]            rnd;
	logic signed [19:0]            hsum;
	logic                          slot_free, out_v_q;
	tcc_pkg::cordic_req_t          creq;
	tcc_pkg::cordic_rsp_t          crsp;

	function automatic logic signed [15:0] q15(input logic signed [tcc_pkg::DW-1:0] v);
		logic signed [tcc_pkg::DW-1:0] t;
		t = (v + 42'sd16384) >>> 15;
		if (t > 42'sd32767) return 16'sd32767;
		else if (t < -42'sd32768) return -16'sd32768;
		else return 16'(t);
	endfunction

	tcc_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.rsp    (crsp)
	);

	// Select operands of the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SQA:   begin mul_a = 32'(item_q.ay); mul_b = 17'(item_q.ay); end
			S_SQB:   begin mul_a = 32'(item_q.az); mul_b = 17'(item_q.az); end
			S_M1:    begin mul_a = 32'(sr_q); mul_b = 17'(sp_q); end
			S_M2:    begin mul_a = 32'(cr_q); mul_b = 17'(sp_q); end
			S_M3:    begin mul_a = t1_q; mul_b = item_q.my; end
			S_M4:    begin mul_a = t2_q; mul_b = item_q.mz; end
			S_M5:    begin mul_a = 32'(cp_q); mul_b = item_q.mx; end
			S_M6:    begin mul_a = 32'(cr_q); mul_b = item_q.my; end
			S_M7:    begin mul_a = 32'(sr_q); mul_b = item_q.mz; end
			S_SCALE: begin mul_a = ang_q; mul_b = HDG_SCALE; end
			default: begin end
		endcase
	end

	assign mul_p = 49'(mul_a) * 49'(mul_b);

	// Square root step: each step takes two bits of the radicand and yields one result bit
	assign bitv  = 32'd1 << {k_q, 1'b0};
	assign trial = res_q + bitv;
	assign res_n = (rem_q >= trial) ? ((res_q >> 1) + bitv) : (res_q >> 1);

	// CORDIC requests
	always_comb begin
		creq.start = 1'b0;
		creq.vec   = 1'b1;
		creq.x     = '0;
		creq.y     = '0;
		creq.z     = '0;
		unique case (state_q)
			S_ROLL_I: begin
				creq.start = 1'b1;
				creq.x     = {{10{item_q.az[15]}}, item_q.az, 16'd0};
				creq.y     = {{10{item_q.ay[15]}}, item_q.ay, 16'd0};
			end
			S_PITCH_I: begin
				creq.start = 1'b1;
				creq.x     = {10'd0, r_q, 16'd0};
				creq.y     = -{{10{item_q.ax[15]}}, item_q.ax, 16'd0};
			end
			S_SCR_I: begin
				creq.start = 1'b1;
				creq.vec   = 1'b0;
				creq.z     = roll_q;
			end
			S_SCP_I: begin
				creq.start = 1'b1;
				creq.vec   = 1'b0;
				creq.z     = pitch_q;
			end
			S_HEAD_I: begin
				creq.start = 1'b1;
				creq.x     = 42'(xh_q);
				creq.y     = 42'(yh_q);
			end
			default: begin end
		endcase
	end

	// Final heading: round the scaled angle, add offset and declination, clamp
	assign rnd  = 47'(prod_q) + 47'sd134217728;
	assign hsum = 20'(rnd >>> 28) + 20'sd18000 + 20'(declination);

	assign q_rd      = (state_q == S_IDLE) && !q_empty;
	assign slot_free = !out_v_q || pop;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:    if (!q_empty) state_q <= q_data.heading ? S_SQA : S_DONE;
				S_SQA:     state_q <= S_SQB;
				S_SQB:     state_q <= S_SQRT;
				S_SQRT:    if (k_q == 4'd0) state_q <= S_ROLL_I;
				S_ROLL_I:  state_q <= S_ROLL_W;
				S_ROLL_W:  if (crsp.done) state_q <= S_PITCH_I;
				S_PITCH_I: state_q <= S_PITCH_W;
				S_PITCH_W: if (crsp.done) state_q <= S_SCR_I;
				S_SCR_I:   state_q <= S_SCR_W;
				S_SCR_W:   if (crsp.done) state_q <= S_SCP_I;
				S_SCP_I:   state_q <= S_SCP_W;
				S_SCP_W:   if (crsp.done) state_q <= S_M1;
				S_M1:      state_q <= S_M2;
				S_M2:      state_q <= S_M3;
				S_M3:      state_q <= S_M4;
				S_M4:      state_q <= S_M5;
				S_M5:      state_q <= S_M6;
				S_M6:      state_q <= S_M7;
				S_M7:      state_q <= S_HEAD_I;
				S_HEAD_I:  state_q <= S_HEAD_W;
				S_HEAD_W:  if (crsp.done) state_q <= S_SCALE;
				S_SCALE:   state_q <= S_FIN;
				S_FIN:     state_q <= S_DONE;
				S_DONE:    if (slot_free) state_q <= S_IDLE;
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				item_q <= q_data;
				hdg_q  <= '0;
			end
			S_SQA: sq_q <= mul_p[31:0];
			S_SQB: begin
				rem_q <= sq_q + mul_p[31:0];
				res_q <= '0;
				k_q   <= 4'd15;
			end
			S_SQRT: begin
				if (rem_q >= trial) rem_q <= rem_q - trial;
				res_q <= res_n;
				k_q   <= k_q - 4'd1;
				r_q   <= res_n[15:0];
			end
			S_ROLL_W:  roll_q  <= crsp.z;
			S_PITCH_W: pitch_q <= crsp.z;
			S_SCR_W: begin
				cr_q <= q15(crsp.x);
				sr_q <= q15(crsp.y);
			end
			S_SCP_W: begin
				cp_q <= q15(crsp.x);
				sp_q <= q15(crsp.y);
			end
			S_M1:     t1_q   <= mul_p[31:0];
			S_M2:     t2_q   <= mul_p[31:0];
			S_M3:     acc_q  <= 50'(mul_p);
			S_M4:     acc_q  <= acc_q + 50'(mul_p);
			S_M5:     xh_q   <= 36'(mul_p) + 36'(acc_q >>> 15);
			S_M6:     yh_q   <= 36'(mul_p);
			S_M7:     yh_q   <= yh_q - 36'(mul_p);
			S_HEAD_W: ang_q  <= crsp.z;
			S_SCALE:  prod_q <= 46'(mul_p);
			S_FIN: begin
				if (hsum > 20'sd65535) hdg_q <= 17'sd65535;
				else if (hsum < -20'sd65536) hdg_q <= -17'sd65536;
				else hdg_q <= 17'(hsum);
			end
			default: begin end
		endcase
	end

	// Result slot: fill when done, drop on a transfer out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (state_q == S_DONE && slot_free) begin
			out_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && slot_free) begin
			heading_centideg <= hdg_q;
			heading_valid    <= item_q.heading;
			offset_report_x  <= item_q.off_x;
			offset_report_y  <= item_q.off_y;
			offset_report_z  <= item_q.off_z;
		end
	end

	assign empty = !out_v_q;

endmodule

/* hw/rtl/tilt_compensated_compass_top.sv */
// Top level of the tilt-compensated compass: front, item queue, back, register port.
// Depends on tcc_pkg, tcc_front, tcc_queue and tcc_back.
//
// Usage:
//  Items enter on a queue-style port: drive mode and the six sensor axes, raise push;
//  the item transfers on a clock edge with push high and full low.
//  Every item gives exactly one result, read queue-style: while empty is low the
//  result sits on the ports; pop transfers it. Calibration modes report the
//  updated hard-iron offsets with heading_valid low; heading mode reports the
//  heading in centidegrees with heading_valid high.
//  A heading item runs one sequencer over a shared multiplier, a 16-step square
//  root and five passes of a single iterative CORDIC; that CORDIC sets the rate,
//  one item at a time.
//  A two-entry queue lets the front take items while the back is busy, and a
//  result slot lets the back finish the next item while a result waits.
//  When pop stays low, the back holds its finished result and the queue fills,
//  then full rises. Reset clears calibration, offsets and queues; declination
//  resets to -45 and is written over the APB port at byte address 0.
module tilt_compensated_compass_top #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         mode,
	input  logic signed [15:0] mag_x,
	input  logic signed [15:0] mag_y,
	input  logic signed [15:0] mag_z,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	output logic               empty,
	input  logic               pop,
	output logic signed [16:0] heading_centideg,
	output logic               heading_valid,
	output logic signed [15:0] offset_report_x,
	output logic signed [15:0] offset_report_y,
	output logic signed [15:0] offset_report_z,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic               q_wr, q_rd, q_empty;
	tcc_pkg::item_t     q_wdata, q_rdata;
	logic signed [15:0] decl_q;
	logic               cfg_wr;

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == tcc_pkg::REG_DECLINATION) ? 32'(decl_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decl_q <= tcc_pkg::DECL_RESET;
		end else if (cfg_wr && paddr[2] == tcc_pkg::REG_DECLINATION) begin
			decl_q <= pwdata[15:0];
		end
	end

	tcc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.mode    (mode),
		.mag_x   (mag_x),
		.mag_y   (mag_y),
		.mag_z   (mag_z),
		.accel_x (accel_x),
		.accel_y (accel_y),
		.accel_z (accel_z),
		.q_full  (full),
		.q_wr    (q_wr),
		.q_data  (q_wdata)
	);

	tcc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_wdata),
		.rd      (q_rd),
		.rd_data (q_rdata),
		.full    (full),
		.empty   (q_empty)
	);

	tcc_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_empty          (q_empty),
		.q_data           (q_rdata),
		.q_rd             (q_rd),
		.declination      (decl_q),
		.pop              (pop),
		.empty            (empty),
		.heading_centideg (heading_centideg),
		.heading_valid    (heading_valid),
		.offset_report_x  (offset_report_x),
		.offset_report_y  (offset_report_y),
		.offset_report_z  (offset_report_z)
	);

	// Calibration results carry a zero heading
	a_cal_zero_heading: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !heading_valid) |-> (heading_centideg == 17'sd0))
		else $error("calibration result with nonzero heading");

	// Headings stay in range while declination is in range
	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && heading_valid && decl_q >= -16'sd18000 && decl_q <= 16'sd18000)
		|-> (heading_centideg >= -17'sd18100 && heading_centideg <= 17'sd54100))
		else $error("heading out of range");

	// Back only takes items that the queue holds
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> !q_empty)
		else $error("queue read while empty");

endmodule
